FILE: rtl/core/rcvf_pkg.sv
`timescale 1ns / 1ps

package rcvf_pkg;

    localparam int SLOTS_DEF       = 32;
    localparam int CHUNK_BYTES_DEF = 64;

    localparam int ARRIVAL_W = 64;
    localparam int BYTE_W    = 8;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_TAKE = 2'd2;

    localparam logic [2:0] ST_POPPED  = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_STORED  = 3'd2;
    localparam logic [2:0] ST_DROPPED = 3'd3;
    localparam logic [2:0] ST_REPORT  = 3'd4;

endpackage

FILE: rtl/core/rcvf_store.sv
`timescale 1ns / 1ps

module rcvf_store
    import rcvf_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int SLOT_W      = $clog2(SLOTS),
    parameter int LEN_W       = $clog2(CHUNK_BYTES + 1),
    parameter int ADDR_W      = $clog2(SLOTS * CHUNK_BYTES)
) (
    input  logic                 aclk,
    input  logic                 wr_byte,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [BYTE_W-1:0]    wr_data,
    input  logic                 wr_arr,
    input  logic                 wr_len,
    input  logic [SLOT_W-1:0]    wr_slot,
    input  logic [ARRIVAL_W-1:0] arr_wdata,
    input  logic [LEN_W-1:0]     len_wdata,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    input  logic [SLOT_W-1:0]    rd_slot,
    output logic [BYTE_W-1:0]    rd_byte,
    output logic [LEN_W-1:0]     rd_len,
    output logic [ARRIVAL_W-1:0] rd_arr
);

    logic [BYTE_W-1:0]    byte_mem [SLOTS*CHUNK_BYTES];
    logic [LEN_W-1:0]     len_mem  [SLOTS];
    logic [ARRIVAL_W-1:0] arr_mem  [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_byte) begin
            byte_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_byte <= byte_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_len) begin
            len_mem[wr_slot] <= len_wdata;
        end
        if (rd_en) begin
            rd_len <= len_mem[rd_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_arr) begin
            arr_mem[wr_slot] <= arr_wdata;
        end
        if (rd_en) begin
            rd_arr <= arr_mem[rd_slot];
        end
    end

endmodule

FILE: rtl/core/chunked_receive_fifo.sv
`timescale 1ns / 1ps

// Receive FIFO of SLOTS chunk slots, each holding up to CHUNK_BYTES bytes, with whole-chunk
// drop when every slot is committed. Bytes, slot lengths and arrival times live in on-chip
// memories with registered reads. A push, a take-overflow or a pop of an empty FIFO has its
// result registered at once; a pop that returns a byte first reads the byte, the length and
// the arrival time of the oldest slot from those memories, and its result is registered
// from their read outputs. An unused action code is accepted and gives no result. Results
// leave through an output register, and a new item is taken only once the previous result
// has left or leaves in the same cycle. No clearing pass is needed after reset.

module chunked_receive_fifo
    import rcvf_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_in [7:0], arrival_in [71:8]
    input  logic [1:0]  s_tuser,   // action [1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // data_out [7:0], arrival_out [71:8], prior_overflow [72]
    output logic [2:0]  m_tuser    // status [2:0]
);

    localparam int PTR_MOD = 2 * SLOTS;
    localparam int PTR_W   = $clog2(PTR_MOD);
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int POS_W   = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int LEN_W   = $clog2(CHUNK_BYTES + 1);
    localparam int ADDR_W  = $clog2(SLOTS * CHUNK_BYTES);

    logic [PTR_W-1:0]     wp_reg, wp_next, rp_reg, rp_next;
    logic [POS_W-1:0]     rpos_reg, rpos_next, fill_reg, fill_next;
    logic                 drop_reg, drop_next, ovf_reg, ovf_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           out_status_reg, out_status_next;
    logic [BYTE_W-1:0]    out_data_reg, out_data_next;
    logic [ARRIVAL_W-1:0] out_arr_reg, out_arr_next;
    logic                 out_had_reg, out_had_next;

    logic                 accept, load;
    logic [1:0]           action;
    logic [BYTE_W-1:0]    data_in;
    logic [ARRIVAL_W-1:0] arrival_in;
    logic [PTR_W-1:0]     wslot_full, rslot_full, count;
    logic [SLOT_W-1:0]    wslot, rslot;
    logic [LEN_W-1:0]     new_fill, rpos_plus;
    logic                 full, empty, commit;

    logic                 wr_byte, wr_arr, wr_len, rd_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [BYTE_W-1:0]    rd_byte;
    logic [LEN_W-1:0]     rd_len;
    logic [ARRIVAL_W-1:0] rd_arr;

    assign action     = s_tuser;
    assign data_in    = s_tdata[7:0];
    assign arrival_in = s_tdata[71:8];

    assign s_tready = !pend_reg && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign wslot_full = (wp_reg >= PTR_W'(SLOTS)) ? wp_reg - PTR_W'(SLOTS) : wp_reg;
    assign rslot_full = (rp_reg >= PTR_W'(SLOTS)) ? rp_reg - PTR_W'(SLOTS) : rp_reg;
    assign wslot      = wslot_full[SLOT_W-1:0];
    assign rslot      = rslot_full[SLOT_W-1:0];
    assign count      = wp_reg - rp_reg + ((wp_reg < rp_reg) ? PTR_W'(PTR_MOD) : PTR_W'(0));
    assign full       = count >= PTR_W'(SLOTS);
    assign empty      = wp_reg == rp_reg;
    assign new_fill   = LEN_W'(fill_reg) + LEN_W'(1);
    assign commit     = s_tlast || (new_fill == LEN_W'(CHUNK_BYTES));
    assign rpos_plus  = LEN_W'(rpos_reg) + LEN_W'(1);

    assign wr_addr = ADDR_W'(wslot) * ADDR_W'(CHUNK_BYTES) + ADDR_W'(fill_reg);
    assign rd_addr = ADDR_W'(rslot) * ADDR_W'(CHUNK_BYTES) + ADDR_W'(rpos_reg);

    always_comb begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        rpos_next       = rpos_reg;
        fill_next       = fill_reg;
        drop_next       = drop_reg;
        ovf_next        = ovf_reg;
        pend_next       = 1'b0;
        load            = 1'b0;
        out_status_next = out_status_reg;
        out_data_next   = '0;
        out_arr_next    = '0;
        out_had_next    = 1'b0;
        wr_byte         = 1'b0;
        wr_arr          = 1'b0;
        wr_len          = 1'b0;
        rd_en           = 1'b0;

        if (pend_reg) begin
            load            = 1'b1;
            out_status_next = ST_POPPED;
            out_data_next   = rd_byte;
            out_arr_next    = rd_arr;
            if (rpos_plus >= rd_len) begin
                rpos_next = '0;
                rp_next   = (rp_reg == PTR_W'(PTR_MOD - 1)) ? '0 : rp_reg + PTR_W'(1);
            end else begin
                rpos_next = rpos_plus[POS_W-1:0];
            end
        end else if (accept) begin
            case (action)
                ACT_PUSH: begin
                    load = 1'b1;
                    if (drop_reg) begin
                        out_status_next = ST_DROPPED;
                        if (s_tlast) begin
                            drop_next = 1'b0;
                        end
                    end else if ((fill_reg == '0) && full) begin
                        out_status_next = ST_DROPPED;
                        ovf_next        = 1'b1;
                        drop_next       = !s_tlast;
                    end else begin
                        out_status_next = ST_STORED;
                        wr_byte         = 1'b1;
                        wr_arr          = fill_reg == '0;
                        if (commit) begin
                            wr_len    = 1'b1;
                            fill_next = '0;
                            wp_next   = (wp_reg == PTR_W'(PTR_MOD - 1)) ? '0
                                                                        : wp_reg + PTR_W'(1);
                        end else begin
                            fill_next = new_fill[POS_W-1:0];
                        end
                    end
                end
                ACT_POP: begin
                    if (empty) begin
                        load            = 1'b1;
                        out_status_next = ST_EMPTY;
                    end else begin
                        rd_en     = 1'b1;
                        pend_next = 1'b1;
                    end
                end
                ACT_TAKE: begin
                    load            = 1'b1;
                    out_status_next = ST_REPORT;
                    out_had_next    = ovf_reg;
                    if (ovf_reg) begin
                        rp_next   = wp_reg;
                        rpos_next = '0;
                        ovf_next  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            rpos_reg      <= '0;
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            rpos_reg      <= rpos_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            ovf_reg       <= ovf_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
            out_arr_reg    <= out_arr_next;
            out_had_reg    <= out_had_next;
        end
    end

    rcvf_store #(
        .SLOTS       (SLOTS),
        .CHUNK_BYTES (CHUNK_BYTES),
        .SLOT_W      (SLOT_W),
        .LEN_W       (LEN_W),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .aclk      (aclk),
        .wr_byte   (wr_byte),
        .wr_addr   (wr_addr),
        .wr_data   (data_in),
        .wr_arr    (wr_arr),
        .wr_len    (wr_len),
        .wr_slot   (wslot),
        .arr_wdata (arrival_in),
        .len_wdata (new_fill),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_slot   (rslot),
        .rd_byte   (rd_byte),
        .rd_len    (rd_len),
        .rd_arr    (rd_arr)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_had_reg, out_arr_reg, out_data_reg};

`ifndef SYNTHESIS
    a_pend_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !s_tready)
        else $error("item taken while a pop read is outstanding");

    a_pend_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |=> (m_tvalid && (m_tuser == ST_POPPED)))
        else $error("pop read did not produce a popped item");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= PTR_W'(SLOTS))
        else $error("committed slot count exceeds the number of slots");

    a_drop_only_empty_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        drop_reg |-> (fill_reg == '0))
        else $error("chunk drop in progress while the open slot holds bytes");

    a_ready_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !pend_reg) |-> s_tready)
        else $error("input stalled although the output register is being emptied");
`endif

endmodule
